/* sv/erv_pkg.sv */
package erv_pkg;

    // Record delimiters
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    // Saturation point of the per-record byte count
    localparam logic [8:0] TOTAL_MAX  = 9'd511;

    // One input beat: a record byte and its last-byte flag
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_record;
    } t_in_beat;

    // One result beat: verdict and length of a finished record
    typedef struct packed {
        logic       record_ok;
        logic [8:0] record_length;
    } t_out_beat;

    // Letters and white space (space, tab through carriage return)
    function automatic logic is_label_char(input logic [7:0] c);
        is_label_char = (c inside {[8'd65:8'd90], [8'd97:8'd122], 8'd32, [8'd9:8'd13]});
    endfunction

    function automatic logic is_digit_char(input logic [7:0] c);
        is_digit_char = (c inside {[8'd48:8'd57]});
    endfunction

endpackage

/* sv/edge_record_validator.sv */
// Channel | Direction | Handshake                   | Payload
// in      | input     | i_in_valid / o_in_stall     | i_in_beat  (char_code, end_of_record)
// out     | output    | o_out_valid / i_out_stall   | o_out_beat (record_ok, record_length)
//
// One byte per cycle while o_in_stall is low; a last byte passes the input register, then its
// result is taken into the result register. The byte parser between the two is combinational.
// Reset (i_rst_n low, synchronous) empties both registers and returns the parser to the
// first label. A stalled result blocks only a last byte behind it; other bytes keep
// flowing into the parser, so o_in_stall rises only when a last byte meets a held result.
module edge_record_validator #(
    parameter int MAX_LABEL    = 128,
    parameter int KM_FIELD_LEN = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  erv_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output erv_pkg::t_out_beat o_out_beat
);

    logic               r_in_valid;
    erv_pkg::t_in_beat  r_in_beat;
    logic               r_out_valid;
    erv_pkg::t_out_beat r_out_beat;

    logic               out_free;
    logic               advance;
    logic               fire;
    logic               in_take;
    logic               res_valid;
    erv_pkg::t_out_beat res;

    // Pipeline control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = !r_in_beat.end_of_record || out_free;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_beat <= i_in_beat;
        end
    end

    erv_fsm #(
        .MAX_LABEL    (MAX_LABEL),
        .KM_FIELD_LEN (KM_FIELD_LEN)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_beat      (r_in_beat),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_beat <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // a rejected record carries no length
    a_bad_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.record_ok) |-> (o_out_beat.record_length == 9'd0))
        else $error("rejected record with nonzero length");

    // input stalls only for a last byte waiting on a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in_beat.end_of_record && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // a finished record is never dropped into a held result register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> out_free)
        else $error("result produced while output held");

endmodule

/* sv/erv_fsm.sv */
module erv_fsm #(
    parameter int MAX_LABEL    = 128,
    parameter int KM_FIELD_LEN = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  erv_pkg::t_in_beat  i_beat,
    output logic               o_res_valid,
    output erv_pkg::t_out_beat o_res
);

    localparam logic [7:0] LABEL_LIMIT = 8'(MAX_LABEL);
    localparam logic [7:0] INT_LIMIT   = 8'(KM_FIELD_LEN - 2);

    typedef enum logic [2:0] {
        PH_LABEL1,
        PH_LABEL2,
        PH_INT,
        PH_FRAC,
        PH_DONE,
        PH_ERR
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_field_count, n_field_count;
    logic [8:0] r_char_total, n_char_total;
    logic [7:0] c;
    t_phase     ph_in;

    // Per-byte state update
    always_comb begin
        c             = i_beat.char_code;
        n_field_count = r_field_count;
        n_char_total  = r_char_total;
        ph_in         = r_phase;

        // byte count saturates; overflow latches the error
        if (r_char_total >= erv_pkg::TOTAL_MAX) begin
            ph_in = PH_ERR;
        end else begin
            n_char_total = r_char_total + 9'd1;
        end

        n_phase = ph_in;
        case (ph_in)
            PH_LABEL1, PH_LABEL2: begin
                if (c == erv_pkg::CHAR_COLON) begin
                    n_phase       = (ph_in == PH_LABEL1) ? PH_LABEL2 : PH_INT;
                    n_field_count = '0;
                end else if (r_field_count >= LABEL_LIMIT || !erv_pkg::is_label_char(c)) begin
                    n_phase = PH_ERR;
                end else begin
                    n_field_count = r_field_count + 8'd1;
                end
            end
            PH_INT: begin
                if (c == erv_pkg::CHAR_DOT) begin
                    n_phase       = PH_FRAC;
                    n_field_count = '0;
                end else if (r_field_count >= INT_LIMIT || !erv_pkg::is_digit_char(c)) begin
                    n_phase = PH_ERR;
                end else begin
                    n_field_count = r_field_count + 8'd1;
                end
            end
            PH_FRAC: begin
                n_phase = erv_pkg::is_digit_char(c) ? PH_DONE : PH_ERR;
            end
            default: begin
                n_phase = PH_ERR;
            end
        endcase
    end

    // Verdict on the last byte
    assign o_res_valid          = i_fire && i_beat.end_of_record;
    assign o_res.record_ok      = (n_phase == PH_DONE);
    assign o_res.record_length  = (n_phase == PH_DONE) ? n_char_total : 9'd0;

    // State registers; cleared after each record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_LABEL1;
            r_field_count <= '0;
            r_char_total  <= '0;
        end else if (i_fire) begin
            if (i_beat.end_of_record) begin
                r_phase       <= PH_LABEL1;
                r_field_count <= '0;
                r_char_total  <= '0;
            end else begin
                r_phase       <= n_phase;
                r_field_count <= n_field_count;
                r_char_total  <= n_char_total;
            end
        end
    end

    // shortest valid record is "::.d"
    a_min_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.record_ok) |-> (o_res.record_length >= 9'd4))
        else $error("valid record shorter than four bytes");

    // label counter never passes its limit
    a_label_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LABEL1 || r_phase == PH_LABEL2) |-> (r_field_count <= LABEL_LIMIT))
        else $error("label count beyond limit");

    // integer counter never passes its limit
    a_int_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_INT) |-> (r_field_count <= INT_LIMIT))
        else $error("integer digit count beyond limit");

    // a last byte always returns the parser to its start
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_phase == PH_LABEL1 && r_char_total == 9'd0))
        else $error("parser not restarted after record end");

endmodule
